@@ src/charlieplex_pwm_scanner_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the charlieplex PWM scanner.
// Both forms are clocked on i_clk and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHARLIEPLEX_PWM_SCANNER_UNIT_MACROS_SVH
`define CHARLIEPLEX_PWM_SCANNER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPWS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cpws_pkg.sv @@
// ----------------------------------------------------------------------------
// cpws_pkg
// Types, constants and lookup functions shared by the charlieplex PWM
// scanner: the group/slot layout of the 12 LEDs and their initial levels.
// ----------------------------------------------------------------------------
package cpws_pkg;

    localparam int BRIGHT_W  = 6;
    localparam int NUM_SLOTS = 3;
    localparam int NUM_PINS  = 4;
    localparam int NUM_LEDS  = 12;

    typedef logic [BRIGHT_W-1:0]        t_bright;
    typedef t_bright [NUM_SLOTS-1:0]    t_row;

    // Operation codes carried in tuser.
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // One write request into the brightness memory.
    typedef struct packed {
        logic       en;
        logic [1:0] row;
        logic [1:0] slot;
        t_bright    data;
    } t_wr_req;

    // Location of an LED inside the group-ordered memory.
    typedef struct packed {
        logic       ok;
        logic [1:0] row;
        logic [1:0] slot;
    } t_led_loc;

    // Result item, drive_enable in the lowest bits.
    typedef struct packed {
        logic [5:0] ramp_value;
        logic [1:0] active_group;
        logic [3:0] drive_level;
        logic [3:0] drive_enable;
    } t_result;

    // Map an LED number onto its cathode group and anode slot.
    function automatic t_led_loc led_loc(input logic [3:0] idx);
        t_led_loc loc;
        loc = '{ok: 1'b1, row: 2'd0, slot: 2'd0};
        unique case (idx)
            4'd0:    loc = '{ok: 1'b1, row: 2'd0, slot: 2'd0};
            4'd4:    loc = '{ok: 1'b1, row: 2'd0, slot: 2'd1};
            4'd10:   loc = '{ok: 1'b1, row: 2'd0, slot: 2'd2};
            4'd1:    loc = '{ok: 1'b1, row: 2'd1, slot: 2'd0};
            4'd2:    loc = '{ok: 1'b1, row: 2'd1, slot: 2'd1};
            4'd8:    loc = '{ok: 1'b1, row: 2'd1, slot: 2'd2};
            4'd3:    loc = '{ok: 1'b1, row: 2'd2, slot: 2'd0};
            4'd5:    loc = '{ok: 1'b1, row: 2'd2, slot: 2'd1};
            4'd7:    loc = '{ok: 1'b1, row: 2'd2, slot: 2'd2};
            4'd6:    loc = '{ok: 1'b1, row: 2'd3, slot: 2'd0};
            4'd9:    loc = '{ok: 1'b1, row: 2'd3, slot: 2'd1};
            4'd11:   loc = '{ok: 1'b1, row: 2'd3, slot: 2'd2};
            default: loc = '{ok: 1'b0, row: 2'd0, slot: 2'd0};
        endcase
        return loc;
    endfunction

    // Anode pin driven for a given group and slot.
    function automatic logic [1:0] anode_pin(input logic [1:0] grp, input logic [1:0] slot);
        logic [1:0] pin;
        pin = 2'd0;
        unique case ({grp, slot})
            {2'd0, 2'd0}: pin = 2'd1;
            {2'd0, 2'd1}: pin = 2'd2;
            {2'd0, 2'd2}: pin = 2'd3;
            {2'd1, 2'd0}: pin = 2'd0;
            {2'd1, 2'd1}: pin = 2'd2;
            {2'd1, 2'd2}: pin = 2'd3;
            {2'd2, 2'd0}: pin = 2'd1;
            {2'd2, 2'd1}: pin = 2'd0;
            {2'd2, 2'd2}: pin = 2'd3;
            {2'd3, 2'd0}: pin = 2'd2;
            {2'd3, 2'd1}: pin = 2'd1;
            {2'd3, 2'd2}: pin = 2'd0;
            default:      pin = 2'd0;
        endcase
        return pin;
    endfunction

    // Brightness that an entry holds until it is first written.
    function automatic t_bright init_bright(input logic [1:0] grp, input logic [1:0] slot);
        t_bright val;
        val = '0;
        unique case ({grp, slot})
            {2'd0, 2'd0}: val = 6'd8;
            {2'd0, 2'd1}: val = 6'd16;
            {2'd0, 2'd2}: val = 6'd2;
            {2'd1, 2'd0}: val = 6'd63;
            {2'd1, 2'd1}: val = 6'd32;
            {2'd1, 2'd2}: val = 6'd2;
            {2'd2, 2'd0}: val = 6'd16;
            {2'd2, 2'd1}: val = 6'd16;
            {2'd2, 2'd2}: val = 6'd4;
            {2'd3, 2'd0}: val = 6'd8;
            {2'd3, 2'd1}: val = 6'd0;
            {2'd3, 2'd2}: val = 6'd4;
            default:      val = 6'd0;
        endcase
        return val;
    endfunction

endpackage

@@ src/cpws_bright_mem.sv @@
// ----------------------------------------------------------------------------
// cpws_bright_mem
// Brightness memory, one row per cathode group and one slot per anode.
// Synchronous read of one row per cycle, per-slot write, per-entry valid
// bits for the reset table, and forwarding of a same-cycle write.
// ----------------------------------------------------------------------------
module cpws_bright_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpws_pkg::t_wr_req i_wr,
    input  logic [1:0]        i_rd_row,
    output cpws_pkg::t_row    o_rd_data
);

    cpws_pkg::t_row          r_mem [0:3];
    logic [3:0][2:0]         r_vld;
    cpws_pkg::t_row          r_rd;
    logic [2:0]              r_rd_vld;
    logic [1:0]              r_rd_row;
    logic                    r_fwd_en;
    logic [1:0]              r_fwd_slot;
    cpws_pkg::t_bright       r_fwd_data;

    // Storage array: write one slot, read one whole row.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.row][i_wr.slot] <= i_wr.data;
        end
        r_rd <= r_mem[i_rd_row];
    end

    // Valid bits, read-side bookkeeping and the write bypass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= '0;
            r_rd_row <= 2'd0;
            r_fwd_en <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.row][i_wr.slot] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_row];
            r_rd_row <= i_rd_row;
            r_fwd_en <= i_wr.en && (i_wr.row == i_rd_row);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_slot <= i_wr.slot;
        r_fwd_data <= i_wr.data;
    end

    // Merge bypass, stored value and reset table per slot.
    always_comb begin
        for (int s = 0; s < cpws_pkg::NUM_SLOTS; s++) begin
            if (r_fwd_en && (r_fwd_slot == 2'(s))) begin
                o_rd_data[s] = r_fwd_data;
            end else if (r_rd_vld[s]) begin
                o_rd_data[s] = r_rd[s];
            end else begin
                o_rd_data[s] = cpws_pkg::init_bright(r_rd_row, 2'(s));
            end
        end
    end

endmodule

@@ src/cpws_out_reg.sv @@
// ----------------------------------------------------------------------------
// cpws_out_reg
// Output register for result items: holds one item until the sink takes it
// and reports when a new item can be loaded.
// ----------------------------------------------------------------------------
module cpws_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  cpws_pkg::t_result i_result,
    output logic              o_can_load,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [15:0]       o_m_tdata    // drive_enable, drive_level, active_group, ramp_value
);

    logic              r_valid;
    cpws_pkg::t_result r_data;

    // A new item may enter when the register is empty or is being emptied.
    assign o_can_load = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule

@@ src/charlieplex_pwm_scanner_unit.sv @@
// Output: a result item is offered in the cycle after its input item is accepted.
// Throughput: one item per cycle unless the sink stalls; each tick reads one brightness
// row that was fetched in the cycle before, so the single memory read port sets the rate.
// Reset: synchronous, active low; ramp, group and pins clear to all floating,
// and the brightness table reads its initial levels at once, with no sweep.
// ----------------------------------------------------------------------------
// charlieplex_pwm_scanner_unit
// PWM scanner for 12 charlieplexed LEDs on 4 tri-state pins. Tick items step
// the ramp and the cathode group; write items set one LED's brightness.
// ----------------------------------------------------------------------------
`include "charlieplex_pwm_scanner_unit_macros.svh"

module charlieplex_pwm_scanner_unit #(
    parameter int RAMP_BITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,    // led_index, brightness_value
    input  logic [0:0]  i_s_tuser,    // op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata     // drive_enable, drive_level, active_group, ramp_value
);

    localparam int CMP_W = (RAMP_BITS > cpws_pkg::BRIGHT_W) ? RAMP_BITS : cpws_pkg::BRIGHT_W;

    logic [RAMP_BITS-1:0] r_ramp, n_ramp;
    logic [1:0]           r_group, n_group;
    logic                 r_cath, n_cath;
    logic [2:0]           r_anode, n_anode;

    logic                 w_accept;
    cpws_pkg::t_op        w_op;
    logic [3:0]           w_led_index;
    cpws_pkg::t_bright    w_bright_value;
    cpws_pkg::t_led_loc   w_loc;
    cpws_pkg::t_wr_req    w_wr;
    cpws_pkg::t_row       w_row;
    logic [RAMP_BITS-1:0] w_ramp_ahead;
    logic [1:0]           w_rd_row;
    logic [CMP_W-1:0]     w_ramp_ext;
    cpws_pkg::t_result    w_result;
    logic                 w_wr_item;
    logic                 w_no_wrap;
    logic [RAMP_BITS+4:0] w_scan_now;
    logic [2:0]           w_relit;

    // Input item fields.
    assign w_accept       = i_s_tvalid && o_s_tready;
    assign w_op           = cpws_pkg::t_op'(i_s_tuser[0]);
    assign w_led_index    = i_s_tdata[3:0];
    assign w_bright_value = i_s_tdata[9:4];
    assign w_loc          = cpws_pkg::led_loc(w_led_index);

    // Brightness write request for an in-range LED.
    always_comb begin
        w_wr.en   = w_accept && (w_op == cpws_pkg::OP_WRITE) && w_loc.ok;
        w_wr.row  = w_loc.row;
        w_wr.slot = w_loc.slot;
        w_wr.data = w_bright_value;
    end

    // Scan step: advance the ramp, start a new group on wrap, release anodes.
    always_comb begin
        n_ramp  = r_ramp;
        n_group = r_group;
        n_cath  = r_cath;
        n_anode = r_anode;
        if (w_accept && (w_op == cpws_pkg::OP_TICK)) begin
            n_ramp = r_ramp + RAMP_BITS'(1);
            if (n_ramp == '0) begin
                n_group = r_group + 2'd1;
                n_cath  = 1'b1;
                for (int s = 0; s < cpws_pkg::NUM_SLOTS; s++) begin
                    n_anode[s] = (w_row[s] != '0);
                end
            end
            for (int s = 0; s < cpws_pkg::NUM_SLOTS; s++) begin
                if (CMP_W'(w_row[s]) <= CMP_W'(n_ramp)) begin
                    n_anode[s] = 1'b0;
                end
            end
        end
    end

    // Prefetch the row that the next tick will use.
    assign w_ramp_ahead = n_ramp + RAMP_BITS'(1);
    assign w_rd_row     = (w_ramp_ahead == '0) ? n_group + 2'd1 : n_group;

    cpws_bright_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_row  (w_rd_row),
        .o_rd_data (w_row)
    );

    // Pin drive pattern after this item.
    always_comb begin
        w_ramp_ext              = CMP_W'(n_ramp);
        w_result.drive_enable   = '0;
        w_result.drive_level    = '0;
        w_result.active_group   = n_group;
        w_result.ramp_value     = w_ramp_ext[5:0];
        if (n_cath) begin
            w_result.drive_enable[n_group] = 1'b1;
        end
        for (int s = 0; s < cpws_pkg::NUM_SLOTS; s++) begin
            if (n_anode[s]) begin
                w_result.drive_enable[cpws_pkg::anode_pin(n_group, 2'(s))] = 1'b1;
                w_result.drive_level[cpws_pkg::anode_pin(n_group, 2'(s))]  = 1'b1;
            end
        end
    end

    // Scan state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp  <= '0;
            r_group <= 2'd0;
            r_cath  <= 1'b0;
            r_anode <= 3'd0;
        end else begin
            r_ramp  <= n_ramp;
            r_group <= n_group;
            r_cath  <= n_cath;
            r_anode <= n_anode;
        end
    end

    cpws_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_result   (w_result),
        .o_can_load (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Terms watched by the checks below.
    assign w_wr_item  = w_accept && (w_op == cpws_pkg::OP_WRITE);
    assign w_no_wrap  = w_accept && (r_ramp != '1);
    assign w_scan_now = {r_ramp, r_group, r_anode};
    assign w_relit    = n_anode & ~r_anode;

    // Checks on the scan state.
    `CPWS_ASSERT_NOW(a_anode_needs_cathode, r_anode != 3'd0, r_cath, "anode without cathode")
    `CPWS_ASSERT_NEXT(a_write_keeps_scan, w_wr_item, $stable(w_scan_now), "write moved scan")
    `CPWS_ASSERT_NEXT(a_group_only_on_wrap, w_no_wrap, $stable(r_group), "group moved off wrap")
    `CPWS_ASSERT_NOW(a_anode_no_relight, w_no_wrap, w_relit == 3'd0, "anode relit in group")

endmodule

@@ verif/tb_charlieplex_pwm_scanner_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_charlieplex_pwm_scanner_unit
// Stream-level test of the charlieplex PWM scanner. A queue of tick and
// brightness-write items feeds a clocked driver. A scan model inside the
// bench predicts pin enables, pin levels, group and ramp for every accepted
// item, and a clocked monitor checks each result item against it field by
// field. Both stream sides idle at random, with one quiet stretch.
// ----------------------------------------------------------------------------
module tb_charlieplex_pwm_scanner_unit;

    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_FIRST  = 1500;
    localparam int QUIET_LAST   = 2100;

    // One input item: operation, LED number and brightness.
    typedef struct {
        cpws_pkg::t_op     op;
        logic [3:0]        idx;
        cpws_pkg::t_bright val;
    } t_scan_item;

    // LED number and anode pin for each group and slot.
    localparam int GROUP_LED [4][3] = '{'{0, 4, 10}, '{1, 2, 8}, '{3, 5, 7}, '{6, 9, 11}};
    localparam int GROUP_ANODE [4][3] = '{'{1, 2, 3}, '{0, 2, 3}, '{1, 0, 3}, '{2, 1, 0}};
    localparam int START_LEVEL [12] = '{8, 63, 32, 16, 16, 16, 8, 4, 2, 0, 2, 4};

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;     // led_index, brightness_value
    logic [0:0]  s_tuser   = '0;     // op
    logic        m_tready  = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;          // drive_enable, drive_level, active_group, ramp_value

    charlieplex_pwm_scanner_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Items waiting to be sent and pin states waiting to be seen.
    t_scan_item        items_q [$];
    cpws_pkg::t_result pin_state_q [$];

    // Scan model state.
    logic [5:0]        ramp_now;
    logic [1:0]        group_now;
    logic              cathode_on;
    logic [2:0]        anode_lit;
    cpws_pkg::t_bright level_mem [12];

    int cyc;
    int stall_cycles;
    int errors;
    int n_ticks;
    int n_writes;
    int n_ignored;
    int n_group_starts;
    int n_results;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Random idle decision, switched off inside the quiet stretch.
    function automatic bit idle_now();
        if (cyc >= QUIET_FIRST && cyc < QUIET_LAST) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 6;
    endfunction

    // Pin state after one item; the scan model state is updated in place.
    function automatic cpws_pkg::t_result scan_step(t_scan_item it);
        cpws_pkg::t_result r;
        logic [3:0] en;
        logic [3:0] lvl;
        if (it.op == cpws_pkg::OP_WRITE) begin
            n_writes++;
            if (it.idx < 12) begin
                level_mem[it.idx] = it.val;
            end else begin
                n_ignored++;
            end
        end else begin
            n_ticks++;
            ramp_now = ramp_now + 6'd1;
            // Ramp wrap: next cathode goes low, nonzero anodes light up.
            if (ramp_now == 6'd0) begin
                n_group_starts++;
                group_now  = group_now + 2'd1;
                cathode_on = 1'b1;
                for (int s = 0; s < 3; s++) begin
                    anode_lit[s] = (level_mem[GROUP_LED[group_now][s]] != 6'd0);
                end
            end
            // Release every anode whose level the ramp has reached.
            for (int s = 0; s < 3; s++) begin
                if (level_mem[GROUP_LED[group_now][s]] <= ramp_now) begin
                    anode_lit[s] = 1'b0;
                end
            end
        end
        en  = '0;
        lvl = '0;
        if (cathode_on) begin
            en[group_now] = 1'b1;
        end
        for (int s = 0; s < 3; s++) begin
            if (anode_lit[s]) begin
                en[GROUP_ANODE[group_now][s]]  = 1'b1;
                lvl[GROUP_ANODE[group_now][s]] = 1'b1;
            end
        end
        r.drive_enable = en;
        r.drive_level  = lvl;
        r.active_group = group_now;
        r.ramp_value   = ramp_now;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic add_item(cpws_pkg::t_op op, int idx, int val);
        t_scan_item it;
        it.op  = op;
        it.idx = idx[3:0];
        it.val = val[5:0];
        items_q.push_back(it);
    endtask

    // Checked away from the rising edge, when driver and monitor have settled.
    task automatic wait_drained();
        @(negedge i_clk);
        while (items_q.size() != 0 || pin_state_q.size() != 0 || s_tvalid) begin
            @(negedge i_clk);
        end
    endtask

    // Driver: presents the next queued item once the previous one is taken.
    always @(posedge i_clk) begin : drive_items
        t_scan_item it;
        cyc <= cyc + 1;
        m_tready <= !idle_now();
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || o_s_tready) begin
            if (items_q.size() != 0 && !idle_now()) begin
                it = items_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, it.val, it.idx};
                s_tuser  <= it.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on input accepts, checks on output accepts.
    always @(posedge i_clk) begin : watch_items
        t_scan_item it;
        cpws_pkg::t_result want;
        cpws_pkg::t_result got;
        bit moved;
        moved = 1'b0;
        if (i_rst_n && s_tvalid && o_s_tready) begin
            moved = 1'b1;
            it.op  = cpws_pkg::t_op'(s_tuser[0]);
            it.idx = s_tdata[3:0];
            it.val = s_tdata[9:4];
            pin_state_q.push_back(scan_step(it));
        end
        if (i_rst_n && o_m_tvalid && m_tready) begin
            moved = 1'b1;
            n_results++;
            got = o_m_tdata;
            if (pin_state_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, o_m_tdata);
            end else begin
                want = pin_state_q.pop_front();
                check_field("drive_enable", want.drive_enable, got.drive_enable);
                check_field("drive_level", want.drive_level, got.drive_level);
                check_field("active_group", want.active_group, got.active_group);
                check_field("ramp_value", want.ramp_value, got.ramp_value);
            end
        end
        // Watchdog on cycles with no traffic on either side.
        if (moved) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus and end of run.
    initial begin : run_test
        int r;
        int idx;
        int val;
        cyc            = 0;
        stall_cycles   = 0;
        errors         = 0;
        n_ticks        = 0;
        n_writes       = 0;
        n_ignored      = 0;
        n_group_starts = 0;
        n_results      = 0;
        ramp_now       = '0;
        group_now      = '0;
        cathode_on     = 1'b0;
        anode_lit      = '0;
        for (int i = 0; i < 12; i++) begin
            level_mem[i] = START_LEVEL[i];
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: level extremes, alternating bit patterns, ignored indexes,
        // and a level raised after its anode has already been released.
        add_item(cpws_pkg::OP_TICK, 0, 0);
        add_item(cpws_pkg::OP_WRITE, 0, 63);
        add_item(cpws_pkg::OP_WRITE, 9, 63);
        add_item(cpws_pkg::OP_WRITE, 1, 0);
        add_item(cpws_pkg::OP_WRITE, 4, 1);
        add_item(cpws_pkg::OP_WRITE, 10, 21);
        add_item(cpws_pkg::OP_WRITE, 11, 42);
        add_item(cpws_pkg::OP_WRITE, 12, 0);
        add_item(cpws_pkg::OP_WRITE, 13, 42);
        add_item(cpws_pkg::OP_WRITE, 14, 21);
        add_item(cpws_pkg::OP_WRITE, 15, 63);
        add_item(cpws_pkg::OP_TICK, 15, 63);
        add_item(cpws_pkg::OP_TICK, 0, 0);
        add_item(cpws_pkg::OP_WRITE, 4, 0);
        add_item(cpws_pkg::OP_TICK, 0, 0);
        add_item(cpws_pkg::OP_WRITE, 4, 63);
        add_item(cpws_pkg::OP_WRITE, 7, 0);
        add_item(cpws_pkg::OP_TICK, 10, 42);
        add_item(cpws_pkg::OP_WRITE, 2, 63);
        add_item(cpws_pkg::OP_TICK, 0, 0);
        add_item(cpws_pkg::OP_WRITE, 8, 1);
        add_item(cpws_pkg::OP_TICK, 0, 0);

        // Sender holds off until every result of the directed part is in.
        wait_drained();

        // Random: mostly ticks so many groups are scanned, with writes mixed in.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 14) begin
                idx = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15)
                                                  : $urandom_range(0, 11);
                r = $urandom_range(0, 9);
                val = (r < 2) ? 0 : (r < 4) ? 63 : (r < 5) ? 1 : $urandom_range(0, 63);
                add_item(cpws_pkg::OP_WRITE, idx, val);
            end else begin
                add_item(cpws_pkg::OP_TICK, $urandom_range(0, 15), $urandom_range(0, 63));
            end
        end
        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Covered %0d ticks over %0d group starts and %0d writes (%0d ignored).",
                 n_ticks, n_group_starts, n_writes, n_ignored);
        $display("Checked %0d result items, %0d field mismatches.", n_results, errors);
        if (errors == 0 && pin_state_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/cpws_pkg.sv
src/cpws_bright_mem.sv
src/cpws_out_reg.sv
src/charlieplex_pwm_scanner_unit.sv
verif/tb_charlieplex_pwm_scanner_unit.sv
